[rtl/pvm_pkg.sv]
// Shared constants and types of the two-voice PCM player and mixer.
package pvm_pkg;

  localparam int unsigned ADDR_BITS_DEF = 16;
  localparam int unsigned SAMPLE_BITS   = 8;

  // Tick request handed from the voice front end to the mixer; the sound byte arrives separately.
  typedef struct packed {
    logic                          vld;
    logic signed [SAMPLE_BITS-1:0] music_smp;
    logic                          music_has;
    logic                          sound_has;
    logic                          music_act;
    logic                          sound_act;
  } mix_req_t;

endpackage

[rtl/pvm_ram.sv]
// Generic single-port RAM with registered read.
module pvm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/pvm_mix_fifo.sv]
// Saturating two-voice mixer feeding a two-entry result queue.
module pvm_mix_fifo (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  pvm_pkg::mix_req_t                 req_i,
  input  logic [pvm_pkg::SAMPLE_BITS-1:0]   sound_byte_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  // mixed_sample [7:0], music_active [8], sound_active [9], zero [15:10]
  output logic [15:0]                       out_data_o
);
  import pvm_pkg::*;

  localparam int unsigned ENT_BITS = SAMPLE_BITS + 2;
  localparam logic signed [SAMPLE_BITS:0] SAT_MAX = 9'sd127;
  localparam logic signed [SAMPLE_BITS:0] SAT_MIN = -9'sd128;

  logic signed [SAMPLE_BITS:0]   m_ext, s_ext, sum;
  logic signed [SAMPLE_BITS-1:0] sat;
  logic [ENT_BITS-1:0]           ent_d;

  logic [ENT_BITS-1:0] ent_q [2];
  logic                head_q, tail_q;
  logic [1:0]          cnt_q;
  logic                pop;

  always_comb begin
    m_ext = req_i.music_has ? {req_i.music_smp[SAMPLE_BITS-1], req_i.music_smp} : '0;
    s_ext = req_i.sound_has ? {sound_byte_i[SAMPLE_BITS-1], sound_byte_i} : '0;
    sum   = m_ext + s_ext;
    if (sum > SAT_MAX) begin
      sat = SAT_MAX[SAMPLE_BITS-1:0];
    end else if (sum < SAT_MIN) begin
      sat = SAT_MIN[SAMPLE_BITS-1:0];
    end else begin
      sat = sum[SAMPLE_BITS-1:0];
    end
    ent_d = {req_i.sound_act, req_i.music_act, sat};
  end

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = {{(16 - ENT_BITS){1'b0}}, ent_q[head_q]};

  // The front end never issues more ticks than the queue can take.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= 1'b0;
      tail_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (req_i.vld) begin
        tail_q <= ~tail_q;
      end
      if (pop) begin
        head_q <= ~head_q;
      end
      cnt_q <= cnt_q + {1'b0, req_i.vld} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.vld) begin
      ent_q[tail_q] <= ent_d;
    end
  end

endmodule

[rtl/two_voice_pcm_player_mixer_unit.sv]
// Two-voice PCM player: voice sequencing, sample memory and mixer output.
// A tick holds the single sample memory port for a music read, then a sound read; its
// result passes the memory read register, the mixer request register and a queue entry
// before it can transfer out. No input is taken during a tick's sound read.
// At most two ticks are in flight or queued; the input stalls while two are.
// Reset clears voice enables, the held flag and the pipeline; sample memory is not cleared.
module two_voice_pcm_player_mixer_unit #(
  parameter int unsigned ADDR_BITS = pvm_pkg::ADDR_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // address [15:0], write_byte [23:16], length [39:24], loop_on [40],
  // loop_first [56:41], loop_last [72:57], resume_after [73], zero [79:74]
  input  logic [79:0] s_axis_tdata,
  // operation [1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // mixed_sample [7:0], music_active [8], sound_active [9], zero [15:10]
  output logic [15:0] m_axis_tdata
);
  import pvm_pkg::*;

  localparam int unsigned RAM_DEPTH = 2 ** ADDR_BITS;

  typedef enum logic [1:0] {
    OP_TICK        = 2'd0,
    OP_WRITE       = 2'd1,
    OP_START_MUSIC = 2'd2,
    OP_START_SOUND = 2'd3
  } op_e;

  typedef struct packed {
    logic        on;
    logic [15:0] first;
    logic [15:0] last;
  } loop_t;

  function automatic logic [15:0] next_pos(logic [15:0] pos, loop_t lp);
    logic [15:0] p1;
    p1 = pos + 16'd1;
    return (lp.on && (p1 >= lp.last)) ? lp.first : p1;
  endfunction

  // Input fields
  op_e                        op;
  logic [15:0]                in_addr, in_len;
  logic [SAMPLE_BITS-1:0]     in_byte;
  loop_t                      in_loop;
  logic                       in_resume;
  logic                       acc;

  assign op        = op_e'(s_axis_tuser);
  assign in_addr   = s_axis_tdata[15:0];
  assign in_byte   = s_axis_tdata[23:16];
  assign in_len    = s_axis_tdata[39:24];
  assign in_loop   = {s_axis_tdata[40], s_axis_tdata[56:41], s_axis_tdata[72:57]};
  assign in_resume = s_axis_tdata[73];

  // Voice state
  logic                 m_on_q, m_on_d, s_on_q, s_on_d, held_vld_q, held_vld_d;
  logic [ADDR_BITS-1:0] m_base_q, m_base_d, s_base_q, s_base_d, h_base_q, h_base_d;
  logic [15:0]          m_len_q, m_len_d, s_len_q, s_len_d, h_len_q, h_len_d;
  logic [15:0]          m_pos_q, m_pos_d, s_pos_q, s_pos_d, h_pos_q, h_pos_d;
  loop_t                m_loop_q, m_loop_d, s_loop_q, s_loop_d, h_loop_q, h_loop_d;

  // Pipeline control
  logic                 ph2_q;
  logic [1:0]           occ_q;
  logic                 m_has_q, m_has_d, m_act_q, m_act_d;
  mix_req_t             mix_q, mix_d;

  // Memory port
  logic                   ram_we;
  logic [ADDR_BITS-1:0]   ram_addr, m_rd_addr, s_rd_addr;
  logic [SAMPLE_BITS-1:0] ram_rdata;

  logic tick_acc, out_xfer;

  assign s_axis_tready = !ph2_q && (occ_q != 2'd2);
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign tick_acc      = acc && (op == OP_TICK);
  assign out_xfer      = m_axis_tvalid && m_axis_tready;

  // Music voice: advances when a tick is accepted, for the tick's music read, or on a music start.
  always_comb begin
    m_on_d     = m_on_q;
    m_base_d   = m_base_q;
    m_len_d    = m_len_q;
    m_pos_d    = m_pos_q;
    m_loop_d   = m_loop_q;
    held_vld_d = held_vld_q;
    h_base_d   = h_base_q;
    h_len_d    = h_len_q;
    h_pos_d    = h_pos_q;
    h_loop_d   = h_loop_q;
    m_has_d    = 1'b0;
    m_rd_addr  = m_base_q + ADDR_BITS'(m_pos_q);
    if (tick_acc) begin
      if (m_on_q && (m_pos_q < m_len_q)) begin
        m_pos_d = next_pos(m_pos_q, m_loop_q);
        m_has_d = 1'b1;
      end else if (held_vld_q) begin
        // Restore the interrupted track and, if it has bytes left, play its next byte right away.
        held_vld_d = 1'b0;
        m_base_d   = h_base_q;
        m_len_d    = h_len_q;
        m_loop_d   = h_loop_q;
        m_rd_addr  = h_base_q + ADDR_BITS'(h_pos_q);
        if (h_pos_q < h_len_q) begin
          m_on_d  = 1'b1;
          m_pos_d = next_pos(h_pos_q, h_loop_q);
          m_has_d = 1'b1;
        end else begin
          m_on_d  = 1'b0;
          m_pos_d = h_pos_q;
        end
      end else begin
        m_on_d = 1'b0;
      end
    end else if (acc && (op == OP_START_MUSIC)) begin
      if (in_resume && m_on_q) begin
        held_vld_d = 1'b1;
        h_base_d   = m_base_q;
        h_len_d    = m_len_q;
        h_pos_d    = m_pos_q;
        h_loop_d   = m_loop_q;
      end else begin
        held_vld_d = 1'b0;
      end
      m_on_d   = 1'b1;
      m_base_d = ADDR_BITS'(in_addr);
      m_len_d  = in_len;
      m_pos_d  = 16'd0;
      m_loop_d = in_loop;
    end
    m_act_d = m_on_d || held_vld_d;
  end

  // Sound voice: advances during a tick's sound read, after its music read, or on a sound start.
  always_comb begin
    s_on_d    = s_on_q;
    s_base_d  = s_base_q;
    s_len_d   = s_len_q;
    s_pos_d   = s_pos_q;
    s_loop_d  = s_loop_q;
    s_rd_addr = s_base_q + ADDR_BITS'(s_pos_q);
    mix_d     = '0;
    if (ph2_q) begin
      mix_d.vld       = 1'b1;
      mix_d.music_smp = ram_rdata;
      mix_d.music_has = m_has_q;
      mix_d.music_act = m_act_q;
      if (s_on_q && (s_pos_q < s_len_q)) begin
        s_pos_d         = next_pos(s_pos_q, s_loop_q);
        mix_d.sound_has = 1'b1;
      end else begin
        s_on_d = 1'b0;
      end
      mix_d.sound_act = s_on_d;
    end else if (acc && (op == OP_START_SOUND)) begin
      s_on_d   = 1'b1;
      s_base_d = ADDR_BITS'(in_addr);
      s_len_d  = in_len;
      s_pos_d  = 16'd0;
      s_loop_d = in_loop;
    end
  end

  always_comb begin
    ram_we = acc && (op == OP_WRITE);
    priority if (ph2_q) begin
      ram_addr = s_rd_addr;
    end else if (tick_acc) begin
      ram_addr = m_rd_addr;
    end else begin
      ram_addr = ADDR_BITS'(in_addr);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_on_q     <= 1'b0;
      s_on_q     <= 1'b0;
      held_vld_q <= 1'b0;
      ph2_q      <= 1'b0;
      occ_q      <= 2'd0;
      mix_q      <= '0;
    end else begin
      m_on_q     <= m_on_d;
      s_on_q     <= s_on_d;
      held_vld_q <= held_vld_d;
      ph2_q      <= tick_acc;
      occ_q      <= occ_q + {1'b0, tick_acc} - {1'b0, out_xfer};
      mix_q      <= mix_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_base_q  <= m_base_d;
    m_len_q   <= m_len_d;
    m_pos_q   <= m_pos_d;
    m_loop_q  <= m_loop_d;
    s_base_q  <= s_base_d;
    s_len_q   <= s_len_d;
    s_pos_q   <= s_pos_d;
    s_loop_q  <= s_loop_d;
    h_base_q  <= h_base_d;
    h_len_q   <= h_len_d;
    h_pos_q   <= h_pos_d;
    h_loop_q  <= h_loop_d;
    if (tick_acc) begin
      m_has_q <= m_has_d;
      m_act_q <= m_act_d;
    end
  end

  pvm_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (RAM_DEPTH)
  ) u_sample_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (in_byte),
    .rdata_o (ram_rdata)
  );

  // The sound byte arrives from memory in the cycle the request is presented.
  pvm_mix_fifo u_mix_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (mix_q),
    .sound_byte_i (ram_rdata),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (m_axis_tdata)
  );

endmodule
